/* rtl/sa_pkg.sv */
// package for the segment allocator: sizes, status and command codes
// no dependencies
package sa_pkg;
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int ADDR_WIDTH_DEF   = 16;
    localparam int FIELD_W          = 16;
    localparam int SLACK_W          = 8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] CFG_FIT_MODE = 2'd0;
    localparam logic [1:0] CFG_MEM_TOTAL = 2'd1;
    localparam logic [1:0] CFG_SLACK    = 2'd2;
endpackage

/* rtl/sa_table.sv */
// free segment table held in flip-flops with shift-up and shift-down moves
// depends on sa_pkg
module sa_table
    import sa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
    localparam int IW = $clog2(MAX_SEGMENTS)
) (
    input  logic                  i_clk,
    input  logic                  i_init,
    input  logic [ADDR_WIDTH-1:0] i_init_len,
    input  logic                  i_wr,
    input  logic [IW-1:0]         i_wr_idx,
    input  logic [ADDR_WIDTH-1:0] i_wr_begin,
    input  logic [ADDR_WIDTH-1:0] i_wr_len,
    input  logic                  i_mv_dn,
    input  logic                  i_mv_up,
    input  logic [IW-1:0]         i_mv_idx,
    input  logic [IW-1:0]         i_rd_idx,
    output logic [ADDR_WIDTH-1:0] o_rd_begin,
    output logic [ADDR_WIDTH-1:0] o_rd_len
);
    logic [ADDR_WIDTH-1:0] r_begin [MAX_SEGMENTS];
    logic [ADDR_WIDTH-1:0] r_len   [MAX_SEGMENTS];

    // a move copies one neighbor entry per cycle; the sequencer walks the index
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_begin[0] <= '0;
            r_len[0]   <= i_init_len;
        end else if (i_mv_dn) begin
            r_begin[i_mv_idx] <= r_begin[i_mv_idx + IW'(1)];
            r_len[i_mv_idx]   <= r_len[i_mv_idx + IW'(1)];
        end else if (i_mv_up) begin
            r_begin[i_mv_idx] <= r_begin[i_mv_idx - IW'(1)];
            r_len[i_mv_idx]   <= r_len[i_mv_idx - IW'(1)];
        end else if (i_wr) begin
            r_begin[i_wr_idx] <= i_wr_begin;
            r_len[i_wr_idx]   <= i_wr_len;
        end
    end

    assign o_rd_begin = r_begin[i_rd_idx];
    assign o_rd_len   = r_len[i_rd_idx];
endmodule

/* rtl/segment_allocator_first_next_fit.sv */
// Variable-partition allocator, first fit or next fit with rover. One request
// at a time: busy rises after the accepting edge and falls in the cycle that
// carries the one-cycle o_valid result. An allocate scans the table one entry
// per cycle (up to MAX_SEGMENTS), then a whole-segment grant shifts later
// entries down one per cycle. A release scans to its address position, then
// merges or shifts entries up one per cycle. The longest allocate is one that
// scans every entry and then removes entry 0. A memory_total write holds busy
// for one cycle while the table reloads. Results cannot be stalled.
module segment_allocator_first_next_fit
    import sa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [FIELD_W-1:0]    i_cfg_data,
    input  logic                  i_cmd,
    input  logic [ADDR_WIDTH-1:0] i_block_size,
    input  logic [ADDR_WIDTH-1:0] i_block_begin,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [ADDR_WIDTH-1:0] o_grant_begin,
    output logic [ADDR_WIDTH-1:0] o_grant_size
);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SEGMENTS);
    localparam logic [ADDR_WIDTH-1:0] AMAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RPRV = 3'd2;
    localparam logic [2:0] S_RNXT = 3'd3;
    localparam logic [2:0] S_SHDN = 3'd4;
    localparam logic [2:0] S_SHUP = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]            r_state, n_state;
    logic                  r_fit, r_init;
    logic [ADDR_WIDTH-1:0] r_total;
    logic [SLACK_W-1:0]    r_slack;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [IW-1:0]         r_rover, n_rover;
    logic                  r_cmd;
    logic [ADDR_WIDTH-1:0] r_size, r_bb;
    logic [IW-1:0]         r_idx, n_idx;      // scan / move pointer
    logic [CW-1:0]         r_k, n_k;          // entries scanned
    logic [CW-1:0]         r_j, n_j;          // release position
    logic [ADDR_WIDTH-1:0] r_plen, n_plen;    // previous entry length
    logic [ADDR_WIDTH-1:0] r_pbeg, n_pbeg;    // previous entry begin
    logic                  r_mprev, n_mprev;
    logic [1:0]            r_st, n_st;
    logic [ADDR_WIDTH-1:0] r_gb, n_gb, r_gs, n_gs;
    logic                  r_vld, n_vld;

    logic                  t_wr, t_dn, t_up;
    logic [IW-1:0]         t_wr_idx, t_mv_idx, t_rd_idx;
    logic [ADDR_WIDTH-1:0] t_wb, t_wl, rd_b, rd_l;

    sa_table #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_WIDTH(ADDR_WIDTH)) u_table (
        .i_clk(i_clk), .i_init(r_init), .i_init_len(r_total),
        .i_wr(t_wr), .i_wr_idx(t_wr_idx), .i_wr_begin(t_wb), .i_wr_len(t_wl),
        .i_mv_dn(t_dn), .i_mv_up(t_up), .i_mv_idx(t_mv_idx),
        .i_rd_idx(t_rd_idx), .o_rd_begin(rd_b), .o_rd_len(rd_l)
    );

    assign busy = (r_state != S_IDLE) || r_init;
    logic accept;
    assign accept = start && !busy;

    // adder / comparator datapath for the scan and merge states
    logic [ADDR_WIDTH:0]   sum_end, bend;
    logic [ADDR_WIDTH+1:0] len_sum;
    logic [ADDR_WIDTH-1:0] diff;
    logic [IW-1:0]         last_idx, nxt_idx;
    assign sum_end  = {1'b0, rd_b} + {1'b0, rd_l};
    assign bend     = {1'b0, r_bb} + {1'b0, r_size};
    assign diff     = rd_l - r_size;
    assign last_idx = IW'(r_cnt - CW'(1));
    assign nxt_idx  = (r_idx == last_idx) ? '0 : r_idx + IW'(1);

    function automatic logic [ADDR_WIDTH-1:0] sat(input logic [ADDR_WIDTH+1:0] v);
        sat = (v > {2'b00, AMAX}) ? AMAX : v[ADDR_WIDTH-1:0];
    endfunction

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_rover = r_rover; n_idx = r_idx;
        n_k = r_k; n_j = r_j; n_plen = r_plen; n_pbeg = r_pbeg; n_mprev = r_mprev;
        n_st = r_st; n_gb = r_gb; n_gs = r_gs; n_vld = 1'b0;
        t_wr = 1'b0; t_dn = 1'b0; t_up = 1'b0;
        t_wr_idx = r_idx; t_mv_idx = r_idx; t_rd_idx = r_idx;
        t_wb = rd_b; t_wl = rd_l; len_sum = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_st = ST_OK; n_gb = '0; n_gs = '0; n_k = '0; n_j = '0;
                    n_mprev = 1'b0;
                    if (i_cmd == CMD_ALLOC) begin
                        if (i_block_size == '0 || r_cnt == '0) begin
                            n_st = ST_NOFIT; n_state = S_DONE;
                        end else begin
                            n_idx = (r_fit && CW'(r_rover) < r_cnt) ? r_rover : '0;
                            n_state = S_SCAN;
                        end
                    end else if (i_block_size == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = '0; n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (rd_l >= r_size) begin
                        n_gb = rd_b;
                        if (diff <= ADDR_WIDTH'(r_slack)) begin
                            n_gs = rd_l;
                            n_cnt = r_cnt - CW'(1);
                            n_j = CW'(r_idx);
                            n_state = S_SHDN;
                        end else begin
                            n_gs = r_size;
                            t_wr = 1'b1; t_wb = rd_b + r_size; t_wl = diff;
                            n_rover = r_idx; n_state = S_DONE;
                        end
                    end else if (r_k + CW'(1) >= r_cnt) begin
                        n_st = ST_NOFIT; n_state = S_DONE;
                    end else begin
                        n_k = r_k + CW'(1); n_idx = nxt_idx;
                    end
                end else begin
                    // find first entry with begin >= block begin
                    if (r_j < r_cnt && rd_b < r_bb) begin
                        n_j = r_j + CW'(1); n_idx = r_idx + IW'(1);
                        n_mprev = sum_end == {1'b0, r_bb};
                        n_plen = rd_l;
                        n_pbeg = rd_b;
                        if (r_j + CW'(1) >= r_cnt) n_state = S_RNXT;
                    end else begin
                        n_state = S_RNXT;
                    end
                end
            end
            S_RNXT: begin
                // r_idx points at entry j; mprev was recorded for j-1
                t_rd_idx = IW'(r_j);
                if (r_j < r_cnt && bend == {1'b0, rd_b}) begin
                    if (r_mprev) begin
                        len_sum = {2'b00, r_plen} + {2'b00, r_size} + {2'b00, rd_l};
                        t_wr = 1'b1; t_wr_idx = IW'(r_j - CW'(1));
                        t_wb = r_pbeg; t_wl = sat(len_sum);
                        n_state = S_RPRV;
                    end else begin
                        len_sum = {2'b00, rd_l} + {2'b00, r_size};
                        t_wr = 1'b1; t_wr_idx = IW'(r_j);
                        t_wb = r_bb; t_wl = sat(len_sum);
                        n_state = S_DONE;
                    end
                end else if (r_mprev) begin
                    len_sum = {2'b00, r_plen} + {2'b00, r_size};
                    t_wr = 1'b1; t_wr_idx = IW'(r_j - CW'(1));
                    t_rd_idx = IW'(r_j - CW'(1));
                    t_wb = rd_b; t_wl = sat(len_sum);
                    n_state = S_DONE;
                end else if (r_cnt >= FULL_CNT) begin
                    n_st = ST_FULL; n_state = S_DONE;
                end else begin
                    n_idx = IW'(r_cnt); n_state = S_SHUP;
                end
            end
            S_RPRV: begin
                // entry j now lives in j-1; drop it
                t_rd_idx = IW'(r_j - CW'(1));
                if (CW'(r_rover) == r_j) n_rover = IW'(r_j - CW'(1));
                n_cnt = r_cnt - CW'(1);
                n_state = S_SHDN;
                n_idx = IW'(r_j);
            end
            S_SHDN: begin
                t_mv_idx = r_idx;
                if (r_state == S_SHDN && CW'(r_idx) + CW'(1) < r_cnt + CW'(1) &&
                    CW'(r_idx) < n_cnt) begin
                    t_dn = 1'b1; n_idx = r_idx + IW'(1);
                end else begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_rover = (r_j < r_cnt) ? IW'(r_j) : '0;
                    end else begin
                        if (CW'(r_rover) > r_j) n_rover = r_rover - IW'(1);
                        if (CW'(n_rover) >= r_cnt) n_rover = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_SHUP: begin
                if (CW'(r_idx) > r_j) begin
                    t_up = 1'b1; t_mv_idx = r_idx; n_idx = r_idx - IW'(1);
                end else begin
                    t_wr = 1'b1; t_wr_idx = IW'(r_j); t_wb = r_bb; t_wl = r_size;
                    if (r_cnt == '0) n_rover = '0;
                    else if (CW'(r_rover) >= r_j) n_rover = r_rover + IW'(1);
                    n_cnt = r_cnt + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_vld = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fit <= 1'b0; r_total <= AMAX;
            r_slack <= SLACK_W'(5); r_init <= 1'b1; r_cnt <= CW'(1);
            r_rover <= '0; r_vld <= 1'b0;
        end else begin
            r_init <= 1'b0;
            r_state <= n_state; r_cnt <= n_cnt; r_rover <= n_rover; r_vld <= n_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIT_MODE:  r_fit <= i_cfg_data[0];
                    CFG_MEM_TOTAL: begin
                        r_total <= ADDR_WIDTH'(i_cfg_data);
                        r_init <= 1'b1; r_rover <= '0;
                        r_cnt <= (i_cfg_data == '0) ? '0 : CW'(1);
                    end
                    CFG_SLACK:     r_slack <= i_cfg_data[SLACK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd; r_size <= i_block_size; r_bb <= i_block_begin;
        end
        r_idx <= n_idx; r_k <= n_k; r_j <= n_j; r_plen <= n_plen; r_pbeg <= n_pbeg;
        r_mprev <= n_mprev; r_st <= n_st; r_gb <= n_gb; r_gs <= n_gs;
    end

    assign o_valid       = r_vld;
    assign o_status      = r_st;
    assign o_grant_begin = (r_st == ST_OK) ? r_gb : '0;
    assign o_grant_size  = (r_st == ST_OK) ? r_gs : '0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("free count beyond table");
    a_vld_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_IDLE) else $error("result while busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> o_valid) else $error("missing result");
endmodule
